FILE: sv/vcsl_pkg.sv
// package: shared constants and fixed-point helpers for the velocity slew limiter
`timescale 1ns / 1ps
package vcsl_pkg;

    localparam int KP_W   = 16;
    localparam int INV_W  = 32;
    localparam int SLEW_W = 24;
    localparam int RAW_W  = 16;
    localparam int EL_W   = 16;
    localparam int Q_W    = 20;
    localparam int CMD_W  = 18;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W = 58;

    localparam logic signed [Q_W-1:0] Q_MAX = 20'sd524287;
    localparam logic signed [Q_W-1:0] Q_MIN = -20'sd524288;

    localparam logic [KP_W-1:0]   KP_RESET   = 16'd1638;
    localparam logic [INV_W-1:0]  INV_RESET  = 32'd1431656;
    localparam logic [SLEW_W-1:0] SLEW_RESET = 24'd10066;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MAX_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_PER_MS   = 2'd2;

    // round to nearest, ties away from zero, then saturate to q3.16
    function automatic logic signed [Q_W-1:0] round_sat(input logic signed [PROD_W-1:0] v,
                                                        input int sh);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] half;
        logic [PROD_W-1:0] r;
        half = PROD_W'(1) << (sh - 1);
        m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        r = (m + half) >> sh;
        if (!v[PROD_W-1])
        begin
            round_sat = (r > PROD_W'(524287)) ? Q_MAX : Q_W'(r);
        end
        else
        begin
            round_sat = (r > PROD_W'(524288)) ? Q_MIN : Q_W'(-r);
        end
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [Q_W:0] v);
        if (v > 21'sd524287)
        begin
            sat_sum = Q_MAX;
        end
        else if (v < -21'sd524288)
        begin
            sat_sum = Q_MIN;
        end
        else
        begin
            sat_sum = v[Q_W-1:0];
        end
    endfunction

endpackage

FILE: sv/velocity_control_slew_limiter_unit.sv
// top level: velocity controller with slew limit on one shared multiplier
//
// channel | signals                                   | dir | handshake
// in      | desired_*, actual_*, elapsed_ms           | in  | in_valid / in_ready
// out     | command_x/y/angle, params_invalid         | out | out_valid / out_ready
// cfg     | cfg_index, cfg_data                       | in  | cfg_we, no wait
//
// one shared 33x25 multiplier serves gains and squares;
// a word whose xy pair needs unit scaling also passes through
// a 20 step square root and two 18 step restoring divisions
// reset clears the held commands and loads the register defaults
// in_ready is high only while idle; a finished word waits in the output
// register and the next word is accepted meanwhile
`timescale 1ns / 1ps
module velocity_control_slew_limiter_unit
    import vcsl_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [RAW_W-1:0]     desired_x,
    input  logic signed [RAW_W-1:0]     desired_y,
    input  logic signed [RAW_W-1:0]     desired_angle,
    input  logic signed [RAW_W-1:0]     actual_x,
    input  logic signed [RAW_W-1:0]     actual_y,
    input  logic signed [RAW_W-1:0]     actual_angle,
    input  logic [EL_W-1:0]             elapsed_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [CMD_W-1:0]     command_x,
    output logic signed [CMD_W-1:0]     command_y,
    output logic signed [Q_W-1:0]       command_angle,
    output logic                        params_invalid
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FF, ST_ERR, ST_ERRW, ST_KP, ST_CMD, ST_LIM, ST_LIMW,
        ST_SLEW, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_DIVS, ST_DIV, ST_DONE
    } state_t;

    state_t state_reg;

    logic signed [KP_W-1:0]   kp_reg;
    logic [INV_W-1:0]         inv_reg;
    logic [SLEW_W-1:0]        slew_reg;

    logic signed [RAW_W-1:0]  des_reg [3];
    logic signed [RAW_W-1:0]  act_reg [3];
    logic [EL_W-1:0]          el_reg;
    logic signed [Q_W-1:0]    applied_reg [3];
    logic signed [Q_W-1:0]    cmd_reg [3];
    logic signed [Q_W-1:0]    ff_reg;
    logic signed [Q_W-1:0]    err_reg;
    logic signed [Q_W-1:0]    ang_reg;
    logic [32:0]              limit_reg;
    logic [39:0]              s_reg;
    logic [39:0]              root_reg;
    logic [4:0]               k_reg;
    logic [1:0]               ax_reg;
    logic                     inv_flag_reg;
    logic [18:0]              dq_reg;
    logic [20:0]              drem_reg;
    logic [17:0]              dnum_reg;
    logic [4:0]               dcnt_reg;
    logic                     dneg_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [32:0]       mul_a;
    logic signed [24:0]       mul_b;
    logic signed [RAW_W:0]    diff_raw;

    logic signed [Q_W-1:0]    cur_cmd;
    logic signed [Q_W-1:0]    cur_prev;
    logic [Q_W:0]             mag_cmd;
    logic [Q_W:0]             mag_prev;
    logic signed [Q_W:0]      slew_diff;
    logic [Q_W:0]             mag_diff;
    logic signed [33:0]       slew_step;
    logic signed [Q_W-1:0]    slew_res;

    logic [39:0]              sq_bit;
    logic [39:0]              sq_trial;
    logic [20:0]              len2;
    logic [36:0]              dnum_full;
    logic [21:0]              dtrial;
    logic [18:0]              dq_next;
    logic [20:0]              drem_next;

    logic signed [Q_W-1:0]    out_x_next;
    logic signed [Q_W-1:0]    out_y_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign diff_raw = (RAW_W+1)'(des_reg[ax_reg]) - (RAW_W+1)'(act_reg[ax_reg]);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FF:
            begin
                mul_a = $signed({1'b0, inv_reg});
                mul_b = 25'(des_reg[ax_reg]);
            end
            ST_ERR:
            begin
                mul_a = $signed({1'b0, inv_reg});
                mul_b = 25'(diff_raw);
            end
            ST_KP:
            begin
                mul_a = 33'(err_reg);
                mul_b = 25'(kp_reg);
            end
            ST_LIM:
            begin
                mul_a = $signed({17'd0, el_reg});
                mul_b = $signed({1'b0, slew_reg});
            end
            ST_SQX:
            begin
                mul_a = 33'(cmd_reg[0]);
                mul_b = 25'(cmd_reg[0]);
            end
            ST_SQY:
            begin
                mul_a = 33'(cmd_reg[1]);
                mul_b = 25'(cmd_reg[1]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // slew limit for the selected axis
    always_comb
    begin
        cur_cmd   = cmd_reg[ax_reg];
        cur_prev  = applied_reg[ax_reg];
        mag_cmd   = cur_cmd[Q_W-1] ? (Q_W+1)'(-(Q_W+1)'(cur_cmd)) : (Q_W+1)'(cur_cmd);
        mag_prev  = cur_prev[Q_W-1] ? (Q_W+1)'(-(Q_W+1)'(cur_prev)) : (Q_W+1)'(cur_prev);
        slew_diff = (Q_W+1)'(cur_cmd) - (Q_W+1)'(cur_prev);
        mag_diff  = slew_diff[Q_W] ? (Q_W+1)'(-slew_diff) : (Q_W+1)'(slew_diff);
        slew_step = slew_diff[Q_W] ? (34'(cur_prev) - $signed({1'b0, limit_reg}))
                                   : (34'(cur_prev) + $signed({1'b0, limit_reg}));
        slew_res  = cur_cmd;
        if (mag_cmd > mag_prev && 33'(mag_diff) > limit_reg)
        begin
            slew_res = slew_step[Q_W-1:0];
        end
    end

    // square root and division steps
    always_comb
    begin
        sq_bit    = 40'(1) << {k_reg, 1'b0};
        sq_trial  = root_reg + sq_bit;
        len2      = {root_reg[19:0], 1'b0};
        dnum_full = ({17'd0, (Q_W)'(cur_cmd[Q_W-1] ? -cur_cmd : cur_cmd)} << 17)
                    + 37'(root_reg[19:0]);
        dtrial    = {drem_reg, dnum_reg[17]};
        if (dtrial >= 22'(len2))
        begin
            drem_next = 21'(dtrial - 22'(len2));
            dq_next   = {dq_reg[17:0], 1'b1};
        end
        else
        begin
            drem_next = dtrial[20:0];
            dq_next   = {dq_reg[17:0], 1'b0};
        end
        out_x_next = (ax_reg == 2'd0) ? (dneg_reg ? -Q_W'(dq_next) : Q_W'(dq_next)) : cmd_reg[0];
        out_y_next = (ax_reg == 2'd1) ? (dneg_reg ? -Q_W'(dq_next) : Q_W'(dq_next)) : cmd_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kp_reg         <= KP_RESET;
            inv_reg        <= INV_RESET;
            slew_reg       <= SLEW_RESET;
            applied_reg[0] <= '0;
            applied_reg[1] <= '0;
            applied_reg[2] <= '0;
            out_valid      <= 1'b0;
            ax_reg         <= '0;
            k_reg          <= '0;
            dcnt_reg       <= '0;
            inv_flag_reg   <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KP_GAIN:       kp_reg   <= cfg_data[KP_W-1:0];
                    REG_INV_MAX_SPEED: inv_reg  <= cfg_data[INV_W-1:0];
                    REG_SLEW_PER_MS:   slew_reg <= cfg_data[SLEW_W-1:0];
                    default:           ;
                endcase
            end

            if (out_valid && out_ready && state_reg != ST_DONE)
            begin
                out_valid <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        des_reg[0]   <= desired_x;
                        des_reg[1]   <= desired_y;
                        des_reg[2]   <= desired_angle;
                        act_reg[0]   <= actual_x;
                        act_reg[1]   <= actual_y;
                        act_reg[2]   <= actual_angle;
                        el_reg       <= elapsed_ms;
                        ax_reg       <= '0;
                        inv_flag_reg <= kp_reg[KP_W-1];
                        state_reg    <= kp_reg[KP_W-1] ? ST_DONE : ST_FF;
                    end
                end
                ST_FF:
                begin
                    state_reg <= ST_ERR;
                end
                ST_ERR:
                begin
                    ff_reg <= round_sat(prod_reg, 16);
                    if (ax_reg == 2'd2)
                    begin
                        ang_reg <= round_sat(prod_reg, 16);
                    end
                    state_reg <= ST_ERRW;
                end
                ST_ERRW:
                begin
                    err_reg   <= round_sat(prod_reg, 16);
                    state_reg <= ST_KP;
                end
                ST_KP:
                begin
                    state_reg <= ST_CMD;
                end
                ST_CMD:
                begin
                    cmd_reg[ax_reg] <= sat_sum((Q_W+1)'(ff_reg)
                                               + (Q_W+1)'(round_sat(prod_reg, 12)));
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= ST_LIM;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_FF;
                    end
                end
                ST_LIM:
                begin
                    state_reg <= ST_LIMW;
                end
                ST_LIMW:
                begin
                    limit_reg <= 33'((prod_reg[39:0] + 40'd128) >> 8);
                    ax_reg    <= '0;
                    state_reg <= ST_SLEW;
                end
                ST_SLEW:
                begin
                    cmd_reg[ax_reg] <= slew_res;
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= ST_SQX;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                ST_SQX:
                begin
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    s_reg     <= prod_reg[39:0];
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    s_reg    <= s_reg + prod_reg[39:0];
                    root_reg <= '0;
                    k_reg    <= 5'd19;
                    if ((s_reg + prod_reg[39:0]) > 40'h1_0000_0000)
                    begin
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SQRT:
                begin
                    if (s_reg >= sq_trial)
                    begin
                        s_reg    <= s_reg - sq_trial;
                        root_reg <= (root_reg >> 1) + sq_bit;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    if (k_reg == 5'd0)
                    begin
                        ax_reg    <= '0;
                        state_reg <= ST_DIVS;
                    end
                    else
                    begin
                        k_reg <= k_reg - 5'd1;
                    end
                end
                ST_DIVS:
                begin
                    drem_reg  <= {2'b00, dnum_full[36:18]};
                    dnum_reg  <= dnum_full[17:0];
                    dq_reg    <= '0;
                    dneg_reg  <= cur_cmd[Q_W-1];
                    dcnt_reg  <= 5'd17;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    drem_reg <= drem_next;
                    dq_reg   <= dq_next;
                    dnum_reg <= {dnum_reg[16:0], 1'b0};
                    if (dcnt_reg == 5'd0)
                    begin
                        cmd_reg[0] <= out_x_next;
                        cmd_reg[1] <= out_y_next;
                        if (ax_reg == 2'd1)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            ax_reg    <= 2'd1;
                            state_reg <= ST_DIVS;
                        end
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg - 5'd1;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid      <= 1'b1;
                        params_invalid <= inv_flag_reg;
                        if (inv_flag_reg)
                        begin
                            command_x     <= '0;
                            command_y     <= '0;
                            command_angle <= '0;
                        end
                        else
                        begin
                            command_x      <= cmd_reg[0][CMD_W-1:0];
                            command_y      <= cmd_reg[1][CMD_W-1:0];
                            command_angle  <= ang_reg;
                            applied_reg[0] <= cmd_reg[0];
                            applied_reg[1] <= cmd_reg[1];
                            applied_reg[2] <= cmd_reg[2];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/vcsl_checker.sv
// checker: port-level properties of the velocity slew limiter, with its bind
`timescale 1ns / 1ps
module vcsl_checker
    import vcsl_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [CMD_W-1:0] command_x,
    input logic signed [CMD_W-1:0] command_y,
    input logic signed [Q_W-1:0]   command_angle,
    input logic                    params_invalid
);

    // invalid gain gives zero commands
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && params_invalid |-> command_x == '0 && command_y == '0
                                        && command_angle == '0)
        else $error("nonzero command with invalid gain");

    // xy commands stay within unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> command_x >= -18'sd65536 && command_x <= 18'sd65536
                      && command_y >= -18'sd65536 && command_y <= 18'sd65536)
        else $error("xy command out of unit range");

    // in_ready goes low once a word has been accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready straight after accepting a word");

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_x)
                                    && $stable(command_y) && $stable(command_angle))
        else $error("waiting result changed");

endmodule

bind velocity_control_slew_limiter_unit vcsl_checker u_vcsl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command_x      (command_x),
    .command_y      (command_y),
    .command_angle  (command_angle),
    .params_invalid (params_invalid)
);
